[design/longest_prefix_match_table_core_macros.svh]
// Assertion macros for the routing table core design file.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LONGEST_PREFIX_MATCH_TABLE_CORE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lpm_pkg.sv]
// Shared constants, action codes and table port types for the routing table.
// Depends on nothing; used by lpm_table and longest_prefix_match_table_core.
package lpm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = 6;
   localparam int WORD_W      = 32;
   localparam int CNT_W       = IDX_W + 1;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   // Write request into the table memory
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] prefix;
      logic [WORD_W-1:0] mask;
      logic              valid;
   } tbl_wr_type;

   // Read request into the table memory
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } tbl_rd_type;

   // Registered read response from the table memory
   typedef struct packed {
      logic [WORD_W-1:0] prefix;
      logic [WORD_W-1:0] mask;
      logic              mark;
   } tbl_data_type;

endpackage

[design/lpm_table.sv]
// Route table storage: prefix/mask memory with registered read,
// plus per-slot valid marks cleared at reset. Depends on lpm_pkg.
module lpm_table (
   input  logic                  clock,
   input  logic                  reset,
   input  lpm_pkg::tbl_wr_type   wr,
   input  lpm_pkg::tbl_rd_type   rd,
   output lpm_pkg::tbl_data_type rd_data
);

   logic [2*lpm_pkg::WORD_W-1:0] mem [lpm_pkg::TABLE_DEPTH];
   logic [lpm_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [2*lpm_pkg::WORD_W-1:0] rd_word_ff;
   logic                         rd_mark_ff;
   logic                         wr_in_range;

   // Drop writes to slots beyond the table
   assign wr_in_range = {1'b0, wr.addr} < lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH);

   // Write prefix and mask together; no read overlaps a write (caller is idle)
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.addr] <= {wr.prefix, wr.mask};
      end
      if (rd.en) begin
         rd_word_ff <= mem[rd.addr];
      end
   end

   // Hold valid marks; clear all at reset, read alongside the memory
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_mark_ff <= 1'b0;
      end else begin
         if (wr.en && wr_in_range) begin
            valid_ff[wr.addr] <= wr.valid;
         end
         if (rd.en) begin
            rd_mark_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data.prefix = rd_word_ff[2*lpm_pkg::WORD_W-1:lpm_pkg::WORD_W];
   assign rd_data.mask   = rd_word_ff[lpm_pkg::WORD_W-1:0];
   assign rd_data.mark   = rd_mark_ff;

endmodule

[design/longest_prefix_match_table_core.sv]
// Channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// request   | start in, busy out         | req_action, req_entry_*, req_lookup_addr
// response  | rsp_strobe out (one cycle) | rsp_hit, rsp_match_index, rsp_match_mask
//
// A write transaction goes straight into the table; busy stays low and the next one may follow.
// A lookup scans all TABLE_DEPTH slots through one memory read port, one slot a
// cycle, and takes no new request until the scan is done; busy drops in the same
// cycle as the response strobe.
// Synchronous reset clears all valid marks at once; the table is usable right away.
// The receiver cannot stall; each response shows for exactly one cycle.
// Depends on lpm_pkg, lpm_table and longest_prefix_match_table_core_macros.svh.
`include "longest_prefix_match_table_core_macros.svh"

module longest_prefix_match_table_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [0:0]                  req_action,
   input  logic [lpm_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [lpm_pkg::WORD_W-1:0]  req_entry_prefix,
   input  logic [lpm_pkg::WORD_W-1:0]  req_entry_mask,
   input  logic [0:0]                  req_entry_valid,
   input  logic [lpm_pkg::WORD_W-1:0]  req_lookup_addr,
   output logic                        rsp_strobe,
   output logic [0:0]                  rsp_hit,
   output logic [lpm_pkg::IDX_W-1:0]   rsp_match_index,
   output logic [lpm_pkg::WORD_W-1:0]  rsp_match_mask
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                   state_ff;
   logic [lpm_pkg::CNT_W-1:0]   rd_idx_ff;
   logic                        cmp_vld_ff;
   logic [lpm_pkg::IDX_W-1:0]   cmp_idx_ff;
   logic [lpm_pkg::WORD_W-1:0]  addr_ff;
   logic                        found_ff, found_in;
   logic [lpm_pkg::IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [lpm_pkg::WORD_W-1:0]  best_mask_ff, best_mask_in;
   logic                        rsp_strobe_ff;
   logic                        rsp_hit_ff;
   logic [lpm_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic [lpm_pkg::WORD_W-1:0]  rsp_mask_ff;

   logic                        accept;
   logic                        is_lookup;
   logic                        issue;
   logic                        match;
   logic                        last_cmp;
   lpm_pkg::tbl_wr_type         wr;
   lpm_pkg::tbl_rd_type         rd;
   lpm_pkg::tbl_data_type       rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_lookup = (lpm_pkg::action_type'(req_action) == lpm_pkg::ACT_LOOKUP);
   assign issue     = (state_ff == ST_SCAN)
                      && (rd_idx_ff < lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH));
   assign last_cmp  = cmp_vld_ff
                      && (cmp_idx_ff == lpm_pkg::IDX_W'(lpm_pkg::TABLE_DEPTH - 1));

   // Route write transactions straight into the table
   assign wr.en     = accept && !is_lookup;
   assign wr.addr   = req_entry_index;
   assign wr.prefix = req_entry_prefix;
   assign wr.mask   = req_entry_mask;
   assign wr.valid  = req_entry_valid[0];

   assign rd.en     = issue;
   assign rd.addr   = rd_idx_ff[lpm_pkg::IDX_W-1:0];

   lpm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // Compare the slot just read and keep the best candidate
   always_comb begin
      match        = rd_data.mark
                     && (((addr_ff ^ rd_data.prefix) & rd_data.mask) == '0);
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_mask_in = best_mask_ff;
      if (cmp_vld_ff && match && (!found_ff || (rd_data.mask > best_mask_ff))) begin
         found_in     = 1'b1;
         best_idx_in  = cmp_idx_ff;
         best_mask_in = rd_data.mask;
      end
   end

   // Sequence the scan and register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         cmp_vld_ff    <= issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_lookup) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (last_cmp) begin
                  state_ff      <= ST_IDLE;
                  rsp_strobe_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Advance the read pointer and track best match; payload needs no reset
   always_ff @(posedge clock) begin
      if (accept && is_lookup) begin
         addr_ff      <= req_lookup_addr;
         rd_idx_ff    <= '0;
         found_ff     <= 1'b0;
         best_idx_ff  <= '0;
         best_mask_ff <= '0;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         found_ff     <= found_in;
         best_idx_ff  <= best_idx_in;
         best_mask_ff <= best_mask_in;
      end
      if (issue) begin
         cmp_idx_ff <= rd_idx_ff[lpm_pkg::IDX_W-1:0];
      end
      if (last_cmp) begin
         rsp_hit_ff  <= found_in;
         rsp_idx_ff  <= found_in ? best_idx_in : '0;
         rsp_mask_ff <= found_in ? best_mask_in : '0;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_match_mask  = rsp_mask_ff;

   `LPM_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_strobe && !rsp_hit[0],
      (rsp_match_index == '0) && (rsp_match_mask == '0), "miss with nonzero payload")
   `LPM_ASSERT_NEXT(a_lookup_busy, clock, reset, accept && is_lookup, busy,
      "lookup accepted but busy not raised")
   `LPM_ASSERT_NEXT(a_write_silent, clock, reset, accept && !is_lookup, !rsp_strobe,
      "write transaction produced a response")
   `LPM_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_strobe, !busy && !cmp_vld_ff,
      "response while scan still running")

endmodule

[tb/tb_longest_prefix_match_table_core.sv]
// Self-checking testbench for the longest-prefix-match routing table core.
// Directed table followed by random route writes and lookups under varied idling.
// Depends on lpm_pkg and longest_prefix_match_table_core.
`timescale 1ns / 100ps

module tb_longest_prefix_match_table_core;

   localparam int DIR_COUNT    = 25;
   localparam int PHASE_COUNT  = 4;
   localparam int PHASE_ITEMS  = 300;
   localparam int NUM_BASES    = 4;
   localparam int MAX_GAP      = 60;

   typedef struct packed {
      logic                       hit;
      logic [lpm_pkg::IDX_W-1:0]  index;
      logic [lpm_pkg::WORD_W-1:0] mask;
   } route_result_type;

   // One transaction into the table, with an optional hand-written answer
   typedef struct packed {
      lpm_pkg::action_type        act;
      logic [lpm_pkg::IDX_W-1:0]  index;
      logic [lpm_pkg::WORD_W-1:0] prefix;
      logic [lpm_pkg::WORD_W-1:0] mask;
      logic                       valid;
      logic [lpm_pkg::WORD_W-1:0] addr;
      logic                       typed;
      route_result_type           want;
   } route_step_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [0:0]                  req_action;
   logic [lpm_pkg::IDX_W-1:0]   req_entry_index;
   logic [lpm_pkg::WORD_W-1:0]  req_entry_prefix;
   logic [lpm_pkg::WORD_W-1:0]  req_entry_mask;
   logic [0:0]                  req_entry_valid;
   logic [lpm_pkg::WORD_W-1:0]  req_lookup_addr;
   logic                        rsp_strobe;
   logic [0:0]                  rsp_hit;
   logic [lpm_pkg::IDX_W-1:0]   rsp_match_index;
   logic [lpm_pkg::WORD_W-1:0]  rsp_match_mask;

   // Shadow copy of the routing table
   logic [lpm_pkg::WORD_W-1:0]  route_prefix [lpm_pkg::TABLE_DEPTH];
   logic [lpm_pkg::WORD_W-1:0]  route_mask   [lpm_pkg::TABLE_DEPTH];
   logic                        route_live   [lpm_pkg::TABLE_DEPTH];
   logic [lpm_pkg::WORD_W-1:0]  base_net     [NUM_BASES];

   route_result_type    pending_routes [$];
   route_step_type      dir_steps [DIR_COUNT];

   int unsigned         error_count;
   int unsigned         writes_sent;
   int unsigned         lookups_sent;
   int unsigned         hits_seen;
   int unsigned         misses_seen;

   longest_prefix_match_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_entry_prefix (req_entry_prefix),
      .req_entry_mask   (req_entry_mask),
      .req_entry_valid  (req_entry_valid),
      .req_lookup_addr  (req_lookup_addr),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_match_index  (rsp_match_index),
      .rsp_match_mask   (rsp_match_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the design hangs
   initial begin
      #(5_000_000);
      $display("tb_longest_prefix_match_table_core: FAIL");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Scan the shadow table: longest unsigned mask wins, lowest slot on ties
   function automatic route_result_type best_route(input logic [lpm_pkg::WORD_W-1:0] addr);
      route_result_type r;
      r = '0;
      for (int k = 0; k < lpm_pkg::TABLE_DEPTH; k++) begin
         if (route_live[k] && ((addr & route_mask[k]) == (route_prefix[k] & route_mask[k]))
             && (!r.hit || route_mask[k] > r.mask)) begin
            r.hit   = 1'b1;
            r.index = lpm_pkg::IDX_W'(k);
            r.mask  = route_mask[k];
         end
      end
      return r;
   endfunction

   function automatic logic [lpm_pkg::WORD_W-1:0] prefix_mask(input int unsigned len);
      return (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   // Mostly structured routes and addresses that land on them, some pure noise
   task automatic make_random_step(output route_step_type s);
      int unsigned k;
      s.act    = ($urandom_range(99) < 35) ? lpm_pkg::ACT_WRITE : lpm_pkg::ACT_LOOKUP;
      s.index  = lpm_pkg::IDX_W'($urandom());
      s.prefix = $urandom();
      s.mask   = $urandom();
      s.valid  = 1'($urandom());
      s.addr   = $urandom();
      s.typed  = 1'b0;
      s.want   = '0;
      if (s.act == lpm_pkg::ACT_WRITE) begin
         if ($urandom_range(9) < 7) begin
            s.mask = prefix_mask($urandom_range(32));
         end
         if ($urandom_range(3) != 0) begin
            s.prefix = base_net[$urandom_range(NUM_BASES-1)] ^ ($urandom() & 32'h0000_FFFF);
         end
         s.valid = ($urandom_range(99) < 85);
      end else begin
         k = $urandom_range(9);
         if (k < 6) begin
            k = $urandom_range(lpm_pkg::TABLE_DEPTH-1);
            s.addr = route_prefix[k] ^ ($urandom() & ~route_mask[k]);
            if ($urandom_range(4) == 0) begin
               s.addr ^= 32'h1 << $urandom_range(31);
            end
         end else if (k < 8) begin
            s.addr = base_net[$urandom_range(NUM_BASES-1)] ^ ($urandom() & 32'h0000_FFFF);
         end
      end
   endtask

   // Present one transaction, wait for accept, update the shadow table, then idle
   task automatic run_step(input route_step_type s, input int unsigned idle_pct);
      int unsigned gap;
      start            <= 1'b1;
      req_action       <= s.act;
      req_entry_index  <= s.index;
      req_entry_prefix <= s.prefix;
      req_entry_mask   <= s.mask;
      req_entry_valid  <= s.valid;
      req_lookup_addr  <= s.addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (s.act == lpm_pkg::ACT_WRITE) begin
         route_prefix[s.index] = s.prefix;
         route_mask[s.index]   = s.mask;
         route_live[s.index]   = s.valid;
         writes_sent++;
      end else begin
         pending_routes.push_back(s.typed ? s.want : best_route(s.addr));
         lookups_sent++;
      end
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off new transactions until every lookup has answered
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_routes.size() != 0);
   endtask

   // Check each response against the oldest pending lookup
   always @(posedge clock) begin
      route_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_routes.size() == 0) begin
            report_error($sformatf("response with no lookup pending: hit=%0d index=%0d mask=%h",
                                   rsp_hit, rsp_match_index, rsp_match_mask));
         end else begin
            want = pending_routes.pop_front();
            if (rsp_hit !== want.hit) begin
               report_error($sformatf("hit: got %0d, want %0d", rsp_hit, want.hit));
            end
            if (rsp_match_index !== want.index) begin
               report_error($sformatf("match_index: got %0d, want %0d",
                                      rsp_match_index, want.index));
            end
            if (rsp_match_mask !== want.mask) begin
               report_error($sformatf("match_mask: got %h, want %h",
                                      rsp_match_mask, want.mask));
            end
            if (want.hit) hits_seen++;
            else misses_seen++;
         end
      end
   end

   initial begin
      int unsigned idle_pcts [PHASE_COUNT];
      route_step_type s;

      idle_pcts = '{0, 82, 16, 0};
      error_count  = 0;
      writes_sent  = 0;
      lookups_sent = 0;
      hits_seen    = 0;
      misses_seen  = 0;
      for (int k = 0; k < lpm_pkg::TABLE_DEPTH; k++) begin
         route_prefix[k] = '0;
         route_mask[k]   = '0;
         route_live[k]   = 1'b0;
      end
      for (int k = 0; k < NUM_BASES; k++) base_net[k] = $urandom();

      // Directed transactions: empty table, default route, nesting, ties, removal
      dir_steps[ 0] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'h0000_0000,
                        1'b1, '{1'b0, 6'd0, 32'h0}};
      dir_steps[ 1] = '{lpm_pkg::ACT_LOOKUP, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0, 32'h0}};
      dir_steps[ 2] = '{lpm_pkg::ACT_WRITE,  6'd63, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0,
                        1'b0, '0};
      dir_steps[ 3] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hDEAD_BEEF,
                        1'b1, '{1'b1, 6'd63, 32'h0}};
      dir_steps[ 4] = '{lpm_pkg::ACT_WRITE,  6'd0,  32'hC0A8_0000, 32'hFFFF_0000, 1'b1,
                        32'hFFFF_FFFF, 1'b0, '0};
      dir_steps[ 5] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_1234,
                        1'b1, '{1'b1, 6'd0, 32'hFFFF_0000}};
      dir_steps[ 6] = '{lpm_pkg::ACT_WRITE,  6'd5,  32'hC0A8_1200, 32'hFFFF_FF00, 1'b1, 32'h0,
                        1'b0, '0};
      dir_steps[ 7] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_1234,
                        1'b1, '{1'b1, 6'd5, 32'hFFFF_FF00}};
      dir_steps[ 8] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A9_0000,
                        1'b1, '{1'b1, 6'd63, 32'h0}};
      dir_steps[ 9] = '{lpm_pkg::ACT_WRITE,  6'd10, 32'hC0A8_0001, 32'hFFFF_0000, 1'b1, 32'h0,
                        1'b0, '0};
      dir_steps[10] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_FFFF,
                        1'b1, '{1'b1, 6'd0, 32'hFFFF_0000}};
      dir_steps[11] = '{lpm_pkg::ACT_WRITE,  6'd1,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,
                        1'b0, '0};
      dir_steps[12] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF,
                        1'b1, '{1'b1, 6'd1, 32'hFFFF_FFFF}};
      dir_steps[13] = '{lpm_pkg::ACT_WRITE,  6'd62, 32'h1234_5678, 32'h8000_0001, 1'b1, 32'h0,
                        1'b0, '0};
      dir_steps[14] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'h9234_5679,
                        1'b0, '0};
      dir_steps[15] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'h7FFF_FFFE,
                        1'b0, '0};
      dir_steps[16] = '{lpm_pkg::ACT_WRITE,  6'd63, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,
                        1'b0, '0};
      dir_steps[17] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_1234,
                        1'b1, '{1'b1, 6'd5, 32'hFFFF_FF00}};
      dir_steps[18] = '{lpm_pkg::ACT_WRITE,  6'd5,  32'hC0A8_1200, 32'hFFFF_FF00, 1'b0, 32'h0,
                        1'b0, '0};
      dir_steps[19] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_1234,
                        1'b1, '{1'b1, 6'd0, 32'hFFFF_0000}};
      dir_steps[20] = '{lpm_pkg::ACT_WRITE,  6'd0,  32'hC0A8_0000, 32'hFFFF_0000, 1'b0, 32'h0,
                        1'b0, '0};
      dir_steps[21] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'hC0A8_1234,
                        1'b1, '{1'b1, 6'd10, 32'hFFFF_0000}};
      dir_steps[22] = '{lpm_pkg::ACT_WRITE,  6'd10, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,
                        1'b0, '0};
      dir_steps[23] = '{lpm_pkg::ACT_WRITE,  6'd62, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0,
                        1'b0, '0};
      dir_steps[24] = '{lpm_pkg::ACT_LOOKUP, 6'd0,  32'h0, 32'h0, 1'b0, 32'h0000_0000,
                        1'b1, '{1'b0, 6'd0, 32'h0}};

      // Drive every input known, then hold reset
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= lpm_pkg::ACT_WRITE;
      req_entry_index  <= '0;
      req_entry_prefix <= '0;
      req_entry_mask   <= '0;
      req_entry_valid  <= 1'b0;
      req_lookup_addr  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++) run_step(dir_steps[i], 0);

      // Random phases, each starting from a drained pipeline
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_drain();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            make_random_step(s);
            run_step(s, idle_pcts[p]);
         end
      end

      wait_for_drain();
      repeat (lpm_pkg::TABLE_DEPTH + 4) @(posedge clock);

      $display("Covered %0d route writes and %0d lookups (%0d hits, %0d misses),",
               writes_sent, lookups_sent, hits_seen, misses_seen);
      $display("with sender idling at 0, 82 and 16 percent; %0d mismatches.", error_count);
      if (error_count == 0 && pending_routes.size() == 0) begin
         $display("tb_longest_prefix_match_table_core: PASS");
      end else begin
         $display("tb_longest_prefix_match_table_core: FAIL");
      end
      $finish;
   end

endmodule
